// ----- rtl/ptb_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptb_pkg
// Shared types, codes and constants for the prescaled timer bank.
// ----------------------------------------------------------------------------
package ptb_pkg;

    // Access codes carried by one input beat
    typedef enum logic [1:0] {
        FUNC_TICK  = 2'd0,
        FUNC_WRITE = 2'd1,
        FUNC_READ  = 2'd2,
        FUNC_NOP   = 2'd3
    } func_t;

    // Byte lanes within one timer's register window
    typedef enum logic [1:0] {
        BYTE_LO   = 2'd0,
        BYTE_HI   = 2'd1,
        BYTE_CTRL = 2'd2,
        BYTE_NONE = 2'd3
    } byte_sel_t;

    localparam int DEF_NUM_TIMERS   = 4;
    localparam int DEF_COUNTER_BITS = 16;

    // Timers reachable through the 2-bit timer field of the address
    localparam int ADDR_TIMERS  = 4;
    localparam int SEL_BITS     = 2;
    localparam int PULSE_BITS   = 4;
    localparam int CYCLE_BITS   = 10;

    localparam logic [7:0] CTRL_WRITE_MASK = 8'hC7;
    localparam int CTRL_CASCADE_BIT = 2;
    localparam int CTRL_IRQ_BIT     = 6;
    localparam int CTRL_ENABLE_BIT  = 7;

    localparam logic [1:0] DELAY_START = 2'd2;
    localparam logic [1:0] DELAY_LOAD  = 2'd1;
    localparam logic [1:0] DELAY_IDLE  = 2'd0;

    // Per-timer command for the cycle in which a beat is processed
    typedef struct packed {
        logic      tick;
        logic      wr_en;
        byte_sel_t byte_sel;
        logic [7:0] wdata;
    } tmr_cmd_t;

    // Prescaler mask: count when (cycle & mask) == 0
    function automatic logic [CYCLE_BITS-1:0] presc_mask(input logic [1:0] sel);
        logic [CYCLE_BITS-1:0] m;
        begin
            case (sel)
                2'd0:    m = 10'h000;
                2'd1:    m = 10'h03F;
                2'd2:    m = 10'h0FF;
                2'd3:    m = 10'h3FF;
                default: m = 10'h000;
            endcase
            return m;
        end
    endfunction

endpackage
`default_nettype wire

// ----- rtl/ptb_timer.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptb_timer
// One timer channel: reload/control registers, pending-write latch, start
// delay, prescaled self count and cascade ripple input.
// ----------------------------------------------------------------------------
module ptb_timer #(
    parameter int TIMER_IDX    = 0,
    parameter int COUNTER_BITS = ptb_pkg::DEF_COUNTER_BITS
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire ptb_pkg::tmr_cmd_t               cmd,
    input  wire logic [ptb_pkg::CYCLE_BITS-1:0]  cycle_count,
    input  wire logic                            carry_in,
    output logic      [COUNTER_BITS-1:0]         count,
    output logic      [7:0]                      ctrl,
    output logic                                 irq,
    output logic                                 ovf
);
    import ptb_pkg::*;

    logic [COUNTER_BITS-1:0] cnt_reg, cnt_next;
    logic [COUNTER_BITS-1:0] rel_act_reg, rel_act_next;
    logic [COUNTER_BITS-1:0] rel_wr_reg, rel_wr_next;
    logic [7:0]              ctrl_reg, ctrl_next;
    logic [1:0]              presc_reg, presc_next;
    logic                    casc_reg, casc_next;
    logic                    irq_en_reg, irq_en_next;
    logic                    run_reg, run_next;
    logic                    act_reg, act_next;
    logic [1:0]              delay_reg, delay_next;
    logic                    pend_reg, pend_next;

    always_comb
    begin
        logic [15:0]             rw16;
        logic [7:0]              wd;
        logic [1:0]              d;
        logic [COUNTER_BITS-1:0] c;
        logic [COUNTER_BITS-1:0] sum;
        logic                    self_cnt;
        logic                    ripple;
        logic                    inc;

        cnt_next     = cnt_reg;
        rel_act_next = rel_act_reg;
        rel_wr_next  = rel_wr_reg;
        ctrl_next    = ctrl_reg;
        presc_next   = presc_reg;
        casc_next    = casc_reg;
        irq_en_next  = irq_en_reg;
        run_next     = run_reg;
        act_next     = act_reg;
        delay_next   = delay_reg;
        pend_next    = pend_reg;
        irq          = 1'b0;
        ovf          = 1'b0;

        rw16 = 16'(rel_wr_reg);
        wd   = cmd.wdata;
        d    = 2'd0;
        c    = cnt_reg;
        sum  = '0;
        self_cnt = 1'b0;
        ripple   = 1'b0;
        inc      = 1'b0;

        if (cmd.wr_en) begin
            case (cmd.byte_sel)
                BYTE_LO:
                begin
                    rel_wr_next = COUNTER_BITS'({rw16[15:8], wd});
                    pend_next   = 1'b1;
                end
                BYTE_HI:
                begin
                    rel_wr_next = COUNTER_BITS'({wd, rw16[7:0]});
                    pend_next   = 1'b1;
                end
                BYTE_CTRL:
                begin
                    if (TIMER_IDX == 0) begin
                        wd[CTRL_CASCADE_BIT] = 1'b0;
                    end
                    ctrl_next = wd & CTRL_WRITE_MASK;
                    pend_next = 1'b1;
                end
                default:
                begin
                end
            endcase
        end

        if (cmd.tick) begin
            // pending register writes take effect first
            if (pend_reg) begin
                pend_next   = 1'b0;
                presc_next  = ctrl_reg[1:0];
                casc_next   = ctrl_reg[CTRL_CASCADE_BIT];
                irq_en_next = ctrl_reg[CTRL_IRQ_BIT];
                if (!run_reg && ctrl_reg[CTRL_ENABLE_BIT]) begin
                    delay_next = DELAY_START;
                    run_next   = 1'b1;
                end else if (run_reg && !ctrl_reg[CTRL_ENABLE_BIT]) begin
                    run_next   = 1'b0;
                    act_next   = 1'b0;
                    delay_next = DELAY_IDLE;
                end
                rel_act_next = rel_wr_reg;
            end

            // start delay: load at one, count from zero
            if (delay_next != DELAY_IDLE) begin
                d = delay_next - 2'd1;
                delay_next = d;
                if (d == DELAY_LOAD) begin
                    c = rel_act_next;
                    if (casc_next) begin
                        delay_next = DELAY_IDLE;
                        act_next   = 1'b0;
                    end
                end else begin
                    act_next = 1'b1;
                end
            end

            self_cnt = act_next && !casc_next
                       && ((cycle_count & presc_mask(presc_next)) == '0);
            ripple   = casc_next && run_next && carry_in;
            inc      = self_cnt || ripple;
            sum      = c + COUNTER_BITS'(1);
            if (inc) begin
                if (sum == '0) begin
                    c   = rel_act_next;
                    ovf = 1'b1;
                    irq = irq_en_next;
                end else begin
                    c = sum;
                end
            end
            cnt_next = c;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cnt_reg     <= '0;
            rel_act_reg <= '0;
            rel_wr_reg  <= '0;
            ctrl_reg    <= '0;
            presc_reg   <= '0;
            casc_reg    <= 1'b0;
            irq_en_reg  <= 1'b0;
            run_reg     <= 1'b0;
            act_reg     <= 1'b0;
            delay_reg   <= DELAY_IDLE;
            pend_reg    <= 1'b0;
        end else begin
            cnt_reg     <= cnt_next;
            rel_act_reg <= rel_act_next;
            rel_wr_reg  <= rel_wr_next;
            ctrl_reg    <= ctrl_next;
            presc_reg   <= presc_next;
            casc_reg    <= casc_next;
            irq_en_reg  <= irq_en_next;
            run_reg     <= run_next;
            act_reg     <= act_next;
            delay_reg   <= delay_next;
            pend_reg    <= pend_next;
        end
    end

    assign count = cnt_reg;
    assign ctrl  = ctrl_reg;

endmodule
`default_nettype wire

// ----- rtl/cascading_prescaled_timer_bank.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cascading_prescaled_timer_bank
// Bank of up-counting timers with prescalers, cascade ripple and IRQ/FIFO
// overflow pulses, driven by tick, byte-write and byte-read beats.
// ----------------------------------------------------------------------------
// One beat is taken every clock while in_stall is low, and each beat yields
// exactly one result beat. A beat waits in the input register until it
// fires; then all of its work (write latch, start delays, prescaled counting
// and the overflow ripple through every timer) is done combinationally and
// lands in the result register: one beat per cycle unless stalled. The
// longest path is the cascade ripple: each timer's overflow gates the count
// enable of the next, chained from timer 0 upward, while the increments and
// zero-detects themselves run side by side. A stalled result does not block
// intake on its own: the input register still takes one beat, and only when
// it is full as well does the input stall. Writes to reload/control bytes
// only take effect at the next tick; a newly enabled timer loads on that tick
// and counts from the one after. Reads return the live counter or control
// byte.
// ----------------------------------------------------------------------------
module cascading_prescaled_timer_bank #(
    parameter int NUM_TIMERS   = ptb_pkg::DEF_NUM_TIMERS,
    parameter int COUNTER_BITS = ptb_pkg::DEF_COUNTER_BITS
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    // input channel
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [1:0] func,
    input  wire logic [3:0] addr,
    input  wire logic [7:0] wdata,
    // result channel
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      rdata,
    output logic [3:0]      irq_pulse,
    output logic [3:0]      fifo_tick
);
    import ptb_pkg::*;

    localparam int SHOWN = (NUM_TIMERS < PULSE_BITS) ? NUM_TIMERS : PULSE_BITS;

    // input register
    logic        in_full_reg, in_full_next;
    func_t       func_reg;
    logic [3:0]  addr_reg;
    logic [7:0]  wdata_reg;

    // result register
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  rdata_reg, rdata_next;
    logic [3:0]  irq_reg, irq_next;
    logic [3:0]  fifo_reg, fifo_next;

    logic [CYCLE_BITS-1:0] cycle_reg, cycle_next;

    logic fire;
    logic take;

    logic [SEL_BITS-1:0] sel;
    byte_sel_t           bsel;
    logic [NUM_TIMERS-1:0] hit;
    logic [NUM_TIMERS-1:0] irq_vec;
    logic [NUM_TIMERS-1:0] ovf_vec;
    logic [COUNTER_BITS-1:0] cnt_arr  [NUM_TIMERS];
    logic [7:0]              ctrl_arr [NUM_TIMERS];
    tmr_cmd_t                cmd_arr  [NUM_TIMERS];

    // handshake: the held beat moves on whenever the result register frees up
    assign fire     = in_full_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_full_reg && !fire;
    assign take     = in_valid && !in_stall;

    assign sel  = addr_reg[3:2];
    assign bsel = byte_sel_t'(addr_reg[1:0]);

    genvar gi;
    generate
        for (gi = 0; gi < NUM_TIMERS; gi++)
        begin : g_tmr
            if (gi < ADDR_TIMERS)
            begin : g_hit
                assign hit[gi] = (sel == SEL_BITS'(gi));
            end
            else
            begin : g_nohit
                assign hit[gi] = 1'b0;
            end

            assign cmd_arr[gi].tick     = fire && (func_reg == FUNC_TICK);
            assign cmd_arr[gi].wr_en    = fire && (func_reg == FUNC_WRITE) && hit[gi];
            assign cmd_arr[gi].byte_sel = bsel;
            assign cmd_arr[gi].wdata    = wdata_reg;

            if (gi == 0)
            begin : g_first
                ptb_timer #(
                    .TIMER_IDX    (gi),
                    .COUNTER_BITS (COUNTER_BITS)
                ) u_timer (
                    .clk         (clk),
                    .rst_n       (rst_n),
                    .cmd         (cmd_arr[gi]),
                    .cycle_count (cycle_reg),
                    .carry_in    (1'b0),
                    .count       (cnt_arr[gi]),
                    .ctrl        (ctrl_arr[gi]),
                    .irq         (irq_vec[gi]),
                    .ovf         (ovf_vec[gi])
                );
            end
            else
            begin : g_next
                // overflow of the timer below ripples in here
                ptb_timer #(
                    .TIMER_IDX    (gi),
                    .COUNTER_BITS (COUNTER_BITS)
                ) u_timer (
                    .clk         (clk),
                    .rst_n       (rst_n),
                    .cmd         (cmd_arr[gi]),
                    .cycle_count (cycle_reg),
                    .carry_in    (ovf_vec[gi-1]),
                    .count       (cnt_arr[gi]),
                    .ctrl        (ctrl_arr[gi]),
                    .irq         (irq_vec[gi]),
                    .ovf         (ovf_vec[gi])
                );
            end
        end
    endgenerate

    // result of the beat being processed
    always_comb
    begin
        logic [15:0] cv16;

        cv16       = '0;
        rdata_next = '0;
        irq_next   = '0;
        fifo_next  = '0;

        if (func_reg == FUNC_READ)
        begin
            for (int i = 0; i < NUM_TIMERS; i++)
            begin
                if (hit[i])
                begin
                    cv16 = 16'(cnt_arr[i]);
                    case (bsel)
                        BYTE_LO:   rdata_next = cv16[7:0];
                        BYTE_HI:   rdata_next = cv16[15:8];
                        BYTE_CTRL: rdata_next = ctrl_arr[i];
                        default:   rdata_next = '0;
                    endcase
                end
            end
        end

        // tick pulses; only the first four timers are reported
        for (int i = 0; i < SHOWN; i++)
        begin
            irq_next[i]  = irq_vec[i];
            fifo_next[i] = ovf_vec[i];
        end
    end

    always_comb
    begin
        in_full_next   = in_full_reg;
        out_valid_next = out_valid_reg;
        cycle_next     = cycle_reg;

        if (fire)
        begin
            in_full_next   = 1'b0;
            out_valid_next = 1'b1;
            if (func_reg == FUNC_TICK)
            begin
                cycle_next = cycle_reg + CYCLE_BITS'(1);
            end
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (take)
        begin
            in_full_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            cycle_reg     <= '0;
        end
        else
        begin
            in_full_reg   <= in_full_next;
            out_valid_reg <= out_valid_next;
            cycle_reg     <= cycle_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            func_reg  <= func_t'(func);
            addr_reg  <= addr;
            wdata_reg <= wdata;
        end
        if (fire)
        begin
            rdata_reg <= rdata_next;
            irq_reg   <= irq_next;
            fifo_reg  <= fifo_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign rdata     = rdata_reg;
    assign irq_pulse = irq_reg;
    assign fifo_tick = fifo_reg;

    // ------------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------------
    a_irq_within_fifo : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((irq_reg & ~fifo_reg) == '0))
        else $error("irq pulse without matching overflow");

    a_pulse_no_rdata : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (fifo_reg != '0)) |-> (rdata_reg == '0))
        else $error("tick result carries read data");

    a_fire_fills_out : assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> out_valid_reg)
        else $error("processed beat lost from result register");

    a_stall_only_full : assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (in_full_reg && out_valid_reg && out_stall))
        else $error("input stalled with free space");

    a_t0_no_cascade : assert property (@(posedge clk) disable iff (!rst_n)
        !ctrl_arr[0][CTRL_CASCADE_BIT])
        else $error("timer 0 cascade bit set");

endmodule
`default_nettype wire
